>>> rtl/core/pfic_pkg.sv
// shared constants, types and helpers of the pcm fifo interpolating channel
package pfic_pkg;

    localparam int RING_BYTES = 32;
    localparam int MIX_FRAMES = 32768;
    localparam int PTR_W      = $clog2(RING_BYTES);
    localparam int SLOT_W     = $clog2(MIX_FRAMES);
    localparam int FILL_W     = PTR_W + 2;
    localparam int RUN_LIMIT  = 64;
    localparam int RUN_W      = $clog2(RUN_LIMIT);
    localparam int LOW_WATER  = 16;
    localparam int ACC_W      = 21;

    // opcodes carried in the input tuser
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TIMER = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_PHASE_STEP   = 8'd0;
    localparam logic [7:0] CFG_HALF_VOLUME  = 8'd1;
    localparam logic [7:0] CFG_ROUTING      = 8'd2;
    localparam logic [7:0] CFG_SOUND_ENABLE = 8'd3;

    // write and clear request from the sequencer to the sample ring
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             clear;
    } t_ring_req;

    // ring pointer increment with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_BYTES - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/pfic_ring.sv
// sample byte ring: one write port, two registered read ports, per-entry valid bits
module pfic_ring (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfic_pkg::t_ring_req            i_req,
    input  logic [pfic_pkg::PTR_W-1:0]     i_raddr_a,
    input  logic [pfic_pkg::PTR_W-1:0]     i_raddr_b,
    output logic [7:0]                     o_rdata_a,
    output logic [7:0]                     o_rdata_b
);

    logic [7:0]                      r_mem [pfic_pkg::RING_BYTES];
    logic [pfic_pkg::RING_BYTES-1:0] r_valid;
    logic [7:0]                      r_rd_a;
    logic [7:0]                      r_rd_b;
    logic                            r_vld_a;
    logic                            r_vld_b;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    // valid bits: an entry never written since reset or clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_vld_a <= r_valid[i_raddr_a];
            r_vld_b <= r_valid[i_raddr_b];
        end
    end

    assign o_rdata_a = r_vld_a ? r_rd_a : 8'd0;
    assign o_rdata_b = r_vld_b ? r_rd_b : 8'd0;

endmodule

>>> rtl/core/pfic_interp.sv
// shared multiply-add unit: cur + floor(diff * frac / 65536)
module pfic_interp (
    input  logic signed [11:0] i_cur,
    input  logic signed [12:0] i_diff,
    input  logic        [15:0] i_frac,
    output logic signed [11:0] o_value
);

    logic signed [16:0] frac_s;
    logic signed [29:0] prod;
    logic signed [13:0] step;
    logic signed [13:0] sum;

    // arithmetic shift of the product gives the floor
    assign frac_s  = $signed({1'b0, i_frac});
    assign prod    = 30'(i_diff * frac_s);
    assign step    = prod[29:16];
    assign sum     = 14'(i_cur) + step;
    assign o_value = sum[11:0];

endmodule

>>> rtl/core/pcm_fifo_interpolating_channel.sv
// top level of the pcm fifo interpolating channel: sequencer, config and output stage
//
//  channel   direction  beat contents
//  s_axis    in         tdata fifo_word, tuser opcode
//  m_axis    out        tdata mix_slot/left/right, tlast last, tuser refill_request
//  cfg       in         register index and write data, always ready
//
// push: accept, then four byte writes into the ring
// timer: accept, a load state for the two ring reads, then one sample per cycle
// while m_axis is not stalled, through the shared multiply-add unit, 1..64 samples
// clear and the unused opcode end at the accept, with the sequencer left idle
// reset (i_rst_n low, synchronous) clears state, pointers, ring valid bits; inits config
// a stalled m_axis holds its beat in the output register and pauses the run
module pcm_fifo_interpolating_channel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] fifo_word
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [14:0] mix_slot, [26:15] left_value,
                                        // [38:27] right_value, [39] zero
    output logic [0:0]  m_axis_tuser,   // [0] refill_request
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_LOAD = 4'b0100,
        S_RUN  = 4'b1000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [pfic_pkg::PTR_W-1:0]      r_wp;
    logic [pfic_pkg::PTR_W-1:0]      r_rp;
    logic [31:0]                     r_word;
    logic [1:0]                      r_byte_cnt;
    logic [pfic_pkg::ACC_W-1:0]      r_acc;
    logic [pfic_pkg::SLOT_W-1:0]     r_slot;
    logic [pfic_pkg::RUN_W-1:0]      r_count;
    logic signed [11:0]              r_cur;
    logic signed [12:0]              r_diff;
    logic [19:0]                     r_phase_step;
    logic                            r_half;
    logic [1:0]                      r_routing;
    logic                            r_enable;
    logic                            r_out_valid;
    logic [14:0]                     r_out_slot;
    logic [11:0]                     r_out_left;
    logic [11:0]                     r_out_right;
    logic                            r_out_last;
    logic                            r_out_refill;

    pfic_pkg::t_ring_req             ring_req;
    logic [7:0]                      rd_cur;
    logic [7:0]                      rd_nxt;
    logic                            in_fire;
    logic                            out_free;
    logic                            run_fire;
    logic                            run_last;
    logic [pfic_pkg::ACC_W-1:0]      acc_next;
    logic signed [11:0]              cur_full;
    logic signed [11:0]              nxt_full;
    logic signed [11:0]              cur_val;
    logic signed [11:0]              nxt_val;
    logic signed [11:0]              interp_v;
    logic [pfic_pkg::FILL_W-1:0]     fill;
    logic                            fill_low;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign run_fire      = (r_state == S_RUN) && out_free;

    // ring access
    assign ring_req.we    = (r_state == S_PUSH);
    assign ring_req.waddr = r_wp;
    assign ring_req.wdata = r_word[7:0];
    assign ring_req.clear = in_fire && (s_axis_tuser == pfic_pkg::OP_CLEAR);

    pfic_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .i_raddr_a (r_rp),
        .i_raddr_b (pfic_pkg::ptr_inc(r_rp)),
        .o_rdata_a (rd_cur),
        .o_rdata_b (rd_nxt)
    );

    // sample scaling by 16 and optional halving
    assign cur_full = $signed({rd_cur, 4'b0000});
    assign nxt_full = $signed({rd_nxt, 4'b0000});
    assign cur_val  = r_half ? (cur_full >>> 1) : cur_full;
    assign nxt_val  = r_half ? (nxt_full >>> 1) : nxt_full;

    pfic_interp u_interp (
        .i_cur   (r_cur),
        .i_diff  (r_diff),
        .i_frac  (r_acc[15:0]),
        .o_value (interp_v)
    );

    // run control and ring fill level
    assign acc_next = r_acc + pfic_pkg::ACC_W'(r_phase_step);
    assign run_last = (acc_next[pfic_pkg::ACC_W-1:16] != '0)
                   || (r_count == pfic_pkg::RUN_W'(pfic_pkg::RUN_LIMIT - 1));
    always_comb begin
        if (r_wp > r_rp) begin
            fill = pfic_pkg::FILL_W'(r_wp) - pfic_pkg::FILL_W'(r_rp);
        end else begin
            fill = pfic_pkg::FILL_W'(r_wp) + pfic_pkg::FILL_W'(pfic_pkg::RING_BYTES)
                 - pfic_pkg::FILL_W'(r_rp);
        end
    end
    assign fill_low = (fill <= pfic_pkg::FILL_W'(pfic_pkg::LOW_WATER));

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (s_axis_tuser == pfic_pkg::OP_PUSH)) begin
                    n_state = S_PUSH;
                end else if (in_fire && (s_axis_tuser == pfic_pkg::OP_TIMER)) begin
                    n_state = S_LOAD;
                end
            end
            S_PUSH: begin
                if (r_byte_cnt == 2'd3) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (run_fire && run_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_byte_cnt  <= '0;
            r_acc       <= '0;
            r_slot      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && (s_axis_tuser == pfic_pkg::OP_TIMER)) begin
                r_rp <= pfic_pkg::ptr_inc(r_rp);
            end
            if (in_fire) begin
                r_byte_cnt <= '0;
            end else if (r_state == S_PUSH) begin
                r_byte_cnt <= r_byte_cnt + 2'd1;
                r_wp       <= pfic_pkg::ptr_inc(r_wp);
            end
            if (r_state == S_LOAD) begin
                r_acc   <= {{(pfic_pkg::ACC_W - 16){1'b0}}, r_acc[15:0]};
                r_count <= '0;
            end else if (run_fire) begin
                r_acc   <= acc_next;
                r_count <= r_count + pfic_pkg::RUN_W'(1);
                if (r_slot == pfic_pkg::SLOT_W'(pfic_pkg::MIX_FRAMES - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + pfic_pkg::SLOT_W'(1);
                end
            end
            if (run_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // push word shifter and loaded sample pair
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= s_axis_tdata;
        end else if (r_state == S_PUSH) begin
            r_word <= {8'd0, r_word[31:8]};
        end
        if (r_state == S_LOAD) begin
            r_cur  <= cur_val;
            r_diff <= 13'(nxt_val) - 13'(cur_val);
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (run_fire) begin
            r_out_slot   <= 15'(r_slot);
            r_out_left   <= (r_enable && r_routing[1]) ? interp_v : 12'sd0;
            r_out_right  <= (r_enable && r_routing[0]) ? interp_v : 12'sd0;
            r_out_last   <= run_last;
            r_out_refill <= run_last && fill_low;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= 20'd65536;
            r_half       <= 1'b0;
            r_routing    <= 2'd0;
            r_enable     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pfic_pkg::CFG_PHASE_STEP:   r_phase_step <= i_cfg_data;
                pfic_pkg::CFG_HALF_VOLUME:  r_half       <= i_cfg_data[0];
                pfic_pkg::CFG_ROUTING:      r_routing    <= i_cfg_data[1:0];
                pfic_pkg::CFG_SOUND_ENABLE: r_enable     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {1'b0, r_out_right, r_out_left, r_out_slot};
    assign m_axis_tuser[0] = r_out_refill;
    assign m_axis_tlast    = r_out_last;

endmodule

>>> rtl/core/pfic_checker.sv
// port-level checker of the pcm fifo interpolating channel, bound to the top level
module pfic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a refill request only rides on the last beat of a run
    a_refill_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("refill request without last");

    // a timer beat keeps the input closed while the samples are loaded
    a_timer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == pfic_pkg::OP_TIMER))
        |=> !s_axis_tready)
        else $error("input ready right after timer beat");

    // a push beat keeps the input closed partway through the writes of its bytes
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == pfic_pkg::OP_PUSH))
        |=> ##2 !s_axis_tready)
        else $error("input ready during push");

    // a stalled output beat holds its valid, data and last
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind pcm_fifo_interpolating_channel pfic_checker u_pfic_checker (.*);
